// File: src/rdc_pkg.sv
// shared types, widths and helpers for the ray/disk cap intersection block
`timescale 1ns / 1ps
`default_nettype none
package rdc_pkg;

    localparam int unsigned W        = 32;  // Q16.16 word
    localparam int unsigned FRAC     = 16;
    localparam int unsigned MAG_W    = 50;  // magnitude of numer / denom
    localparam int unsigned DIV_STEPS = 32; // quotient bits, one per stage
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd3;

    localparam logic signed [W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [W-1:0] Q_ONE = 32'sh0001_0000;

    // per-item data that rides along the pipeline
    typedef struct packed {
        logic                   side;
        logic signed [W-1:0]    ctr_x;
        logic signed [W-1:0]    ctr_y;
        logic signed [W-1:0]    ctr_z;
        logic signed [W-1:0]    org_x;
        logic signed [W-1:0]    org_y;
        logic signed [W-1:0]    org_z;
        logic signed [W-1:0]    dir_x;
        logic signed [W-1:0]    dir_y;
        logic signed [W-1:0]    dir_z;
        logic signed [W-1:0]    lo;
        logic signed [W-1:0]    hi;
        logic                   den_neg;
        logic                   den_zero;
        logic                   q_neg;
        logic                   q_ovf;
    } pay_t;

    // restoring divider state
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [W-1:0]     alo;
        logic [MAG_W-1:0] dvs;
    } div_t;

    // negate with saturation of the most negative value
    function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        if (v == Q_MIN)
            r = Q_MAX;
        else
            r = -v;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/ray_disk_cap_intersect.sv
// top level: pipelined ray against cylinder end cap intersection
`timescale 1ns / 1ps
`default_nettype none
// Takes one ray/cap test per clock (busy stays low) and returns exactly one
// result per test, as a one-cycle done pulse with hit, t_hit, point, normal
// and front_face. The receiver cannot stall. The divider for t has 32
// stages, one quotient bit each, after four stages of products and sums;
// six stages then form the hit point and the squared distance test. The axis
// and radius registers are read live by stages in flight, so write them only
// with the pipe empty.
module ray_disk_cap_intersect
    import rdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [W-1:0]          cfg_data,
    // command
    input  wire logic                  start,
    output      logic                  busy,
    input  wire logic                  cap_side,
    input  wire logic signed [W-1:0]   center_x,
    input  wire logic signed [W-1:0]   center_y,
    input  wire logic signed [W-1:0]   center_z,
    input  wire logic signed [W-1:0]   origin_x,
    input  wire logic signed [W-1:0]   origin_y,
    input  wire logic signed [W-1:0]   origin_z,
    input  wire logic signed [W-1:0]   dir_x,
    input  wire logic signed [W-1:0]   dir_y,
    input  wire logic signed [W-1:0]   dir_z,
    input  wire logic signed [W-1:0]   t_lower,
    input  wire logic signed [W-1:0]   t_upper,
    // result
    output      logic                  done,
    output      logic                  hit,
    output      logic signed [W-1:0]   t_hit,
    output      logic signed [W-1:0]   point_x,
    output      logic signed [W-1:0]   point_y,
    output      logic signed [W-1:0]   point_z,
    output      logic signed [W-1:0]   norm_x,
    output      logic signed [W-1:0]   norm_y,
    output      logic signed [W-1:0]   norm_z,
    output      logic                  front_face
);

    localparam int unsigned LATENCY = 42;

    // ---------------- configuration registers ----------------
    logic signed [W-1:0] axis_x_reg, axis_y_reg, axis_z_reg, radius_reg;
    logic [W-1:0]        rmag;
    logic [2*W-1:0]      r2_reg;
    logic                cfg_we;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;   // fully pipelined, never holds off a start
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg <= '0;
            axis_y_reg <= '0;
            axis_z_reg <= Q_ONE;
            radius_reg <= Q_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AXIS_X: axis_x_reg <= cfg_data;
                REG_AXIS_Y: axis_y_reg <= cfg_data;
                REG_AXIS_Z: axis_z_reg <= cfg_data;
                REG_RADIUS: radius_reg <= cfg_data;
                default:    ;  // unused index, write dropped
            endcase
        end
    end

    // radius magnitude and its square, precomputed off the item path
    assign rmag = radius_reg[W-1] ? (~radius_reg + 32'd1) : radius_reg;

    always_ff @(posedge clk)
    begin
        r2_reg <= rmag * rmag;
    end

    // ---------------- stage 1: capture, center - origin ----------------
    logic                      v1_reg;
    pay_t                      p1_reg;
    logic signed [W:0]         dx1_reg, dy1_reg, dz1_reg;
    logic                      accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        p1_reg.side     <= cap_side;
        p1_reg.ctr_x    <= center_x;
        p1_reg.ctr_y    <= center_y;
        p1_reg.ctr_z    <= center_z;
        p1_reg.org_x    <= origin_x;
        p1_reg.org_y    <= origin_y;
        p1_reg.org_z    <= origin_z;
        p1_reg.dir_x    <= dir_x;
        p1_reg.dir_y    <= dir_y;
        p1_reg.dir_z    <= dir_z;
        p1_reg.lo       <= t_lower;
        p1_reg.hi       <= t_upper;
        p1_reg.den_neg  <= 1'b0;
        p1_reg.den_zero <= 1'b0;
        p1_reg.q_neg    <= 1'b0;
        p1_reg.q_ovf    <= 1'b0;
        dx1_reg <= 33'(center_x) - 33'(origin_x);
        dy1_reg <= 33'(center_y) - 33'(origin_y);
        dz1_reg <= 33'(center_z) - 33'(origin_z);
    end

    // ---------------- stage 2: six products, floored to Q33.16 / Q32.16 ----------------
    logic                      v2_reg;
    pay_t                      p2_reg;
    logic signed [64:0]        nprod_x, nprod_y, nprod_z;
    logic signed [63:0]        dprod_x, dprod_y, dprod_z;
    logic signed [48:0]        nx2_reg, ny2_reg, nz2_reg;
    logic signed [47:0]        dx2_reg, dy2_reg, dz2_reg;

    assign nprod_x = 65'(dx1_reg) * 65'(axis_x_reg);
    assign nprod_y = 65'(dy1_reg) * 65'(axis_y_reg);
    assign nprod_z = 65'(dz1_reg) * 65'(axis_z_reg);
    assign dprod_x = 64'(p1_reg.dir_x) * 64'(axis_x_reg);
    assign dprod_y = 64'(p1_reg.dir_y) * 64'(axis_y_reg);
    assign dprod_z = 64'(p1_reg.dir_z) * 64'(axis_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    // dropping the low bits of a two's complement value floors it
    always_ff @(posedge clk)
    begin
        p2_reg  <= p1_reg;
        nx2_reg <= nprod_x[64:FRAC];
        ny2_reg <= nprod_y[64:FRAC];
        nz2_reg <= nprod_z[64:FRAC];
        dx2_reg <= dprod_x[63:FRAC];
        dy2_reg <= dprod_y[63:FRAC];
        dz2_reg <= dprod_z[63:FRAC];
    end

    // ---------------- stage 3: numer and denom sums ----------------
    logic                      v3_reg;
    pay_t                      p3_reg;
    logic signed [50:0]        numer3_reg;
    logic signed [49:0]        denom3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        p3_reg     <= p2_reg;
        numer3_reg <= 51'(nx2_reg) + 51'(ny2_reg) + 51'(nz2_reg);
        denom3_reg <= 50'(dx2_reg) + 50'(dy2_reg) + 50'(dz2_reg);
    end

    // ---------------- stage 4: magnitudes, sign, overflow check ----------------
    logic [50:0]               nabs;
    logic [49:0]               dabs;
    logic [MAG_W-1:0]          an4, ad4;
    pay_t                      p4_next;
    div_t                      d4_next;

    assign nabs = numer3_reg[50] ? 51'(-numer3_reg) : 51'(numer3_reg);
    assign dabs = denom3_reg[49] ? 50'(-denom3_reg) : 50'(denom3_reg);
    assign an4  = nabs[MAG_W-1:0];
    assign ad4  = dabs;

    always_comb
    begin
        p4_next          = p3_reg;
        p4_next.den_neg  = denom3_reg[49];
        p4_next.den_zero = (denom3_reg == '0);
        p4_next.q_neg    = numer3_reg[50] != denom3_reg[49];
        // |numer| * 2^16 / |denom| needs more than 32 quotient bits
        p4_next.q_ovf    = (MAG_W'(an4 >> FRAC) >= ad4);
        d4_next.rem      = MAG_W'(an4 >> FRAC);
        d4_next.alo      = {an4[FRAC-1:0], {FRAC{1'b0}}};
        d4_next.dvs      = ad4;
    end

    // ---------------- stages 5..36: restoring divider ----------------
    logic                      dv_v_reg [0:DIV_STEPS];
    pay_t                      dv_p_reg [0:DIV_STEPS];
    div_t                      dv_d_reg [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else
            dv_v_reg[0] <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        dv_p_reg[0] <= p4_next;
        dv_d_reg[0] <= d4_next;
    end

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        div_t           step;

        assign trial = {dv_d_reg[g].rem, dv_d_reg[g].alo[W-1]};
        assign diff  = trial - {1'b0, dv_d_reg[g].dvs};

        always_comb
        begin
            step     = dv_d_reg[g];
            step.dvs = dv_d_reg[g].dvs;
            if (!diff[MAG_W])
            begin
                step.rem = diff[MAG_W-1:0];
                step.alo = {dv_d_reg[g].alo[W-2:0], 1'b1};
            end
            else
            begin
                step.rem = trial[MAG_W-1:0];
                step.alo = {dv_d_reg[g].alo[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[g+1] <= 1'b0;
            else
                dv_v_reg[g+1] <= dv_v_reg[g];
        end

        always_ff @(posedge clk)
        begin
            dv_p_reg[g+1] <= dv_p_reg[g];
            dv_d_reg[g+1] <= step;
        end
    end

    // ---------------- stage 37: signed, saturated t and interval test ----------------
    logic                      v5_reg;
    pay_t                      p5_reg;
    logic signed [W-1:0]       t5_reg;
    logic                      in5_reg;
    logic [W-1:0]              q5;
    logic signed [W-1:0]       t5;
    pay_t                      pq;

    assign q5 = dv_d_reg[DIV_STEPS].alo;
    assign pq = dv_p_reg[DIV_STEPS];

    always_comb
    begin
        if (pq.q_ovf)
            t5 = pq.q_neg ? Q_MIN : Q_MAX;
        else if (pq.q_neg)
            t5 = (q5 > 32'h8000_0000) ? Q_MIN : -$signed(q5);
        else
            t5 = q5[W-1] ? Q_MAX : $signed(q5);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= dv_v_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        p5_reg  <= pq;
        t5_reg  <= t5;
        in5_reg <= (t5 >= pq.lo) && (t5 <= pq.hi);
    end

    // ---------------- stage 38: t * dir ----------------
    logic                      v6_reg;
    pay_t                      p6_reg;
    logic signed [W-1:0]       t6_reg;
    logic                      in6_reg;
    logic signed [63:0]        tpx6_reg, tpy6_reg, tpz6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        p6_reg   <= p5_reg;
        t6_reg   <= t5_reg;
        in6_reg  <= in5_reg;
        tpx6_reg <= 64'(t5_reg) * 64'(p5_reg.dir_x);
        tpy6_reg <= 64'(t5_reg) * 64'(p5_reg.dir_y);
        tpz6_reg <= 64'(t5_reg) * 64'(p5_reg.dir_z);
    end

    // ---------------- stage 39: hit point and offset from center ----------------
    logic                      v7_reg;
    pay_t                      p7_reg;
    logic signed [W-1:0]       t7_reg;
    logic                      in7_reg;
    logic signed [48:0]        ptx7, pty7, ptz7;
    logic signed [48:0]        ptx7_reg, pty7_reg, ptz7_reg;
    logic signed [49:0]        ofx7_reg, ofy7_reg, ofz7_reg;

    // the floored product keeps its sign when widened
    assign ptx7 = 49'(p6_reg.org_x) + 49'($signed(tpx6_reg[63:FRAC]));
    assign pty7 = 49'(p6_reg.org_y) + 49'($signed(tpy6_reg[63:FRAC]));
    assign ptz7 = 49'(p6_reg.org_z) + 49'($signed(tpz6_reg[63:FRAC]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        p7_reg   <= p6_reg;
        t7_reg   <= t6_reg;
        in7_reg  <= in6_reg;
        ptx7_reg <= ptx7;
        pty7_reg <= pty7;
        ptz7_reg <= ptz7;
        ofx7_reg <= 50'(p6_reg.ctr_x) - 50'(ptx7);
        ofy7_reg <= 50'(p6_reg.ctr_y) - 50'(pty7);
        ofz7_reg <= 50'(p6_reg.ctr_z) - 50'(ptz7);
    end

    // ---------------- stage 40: offset magnitudes, reject, point saturation ----------------
    logic                      v8_reg;
    pay_t                      p8_reg;
    logic signed [W-1:0]       t8_reg;
    logic                      in8_reg;
    logic [49:0]               mx8, my8, mz8;
    logic                      far8_reg;
    logic [W-1:0]              mx8_reg, my8_reg, mz8_reg;
    logic signed [W-1:0]       px8_reg, py8_reg, pz8_reg;

    assign mx8 = ofx7_reg[49] ? 50'(-ofx7_reg) : 50'(ofx7_reg);
    assign my8 = ofy7_reg[49] ? 50'(-ofy7_reg) : 50'(ofy7_reg);
    assign mz8 = ofz7_reg[49] ? 50'(-ofz7_reg) : 50'(ofz7_reg);

    function automatic logic signed [W-1:0] sat49(input logic signed [48:0] v);
        logic signed [W-1:0] r;
        if (v > 49'(Q_MAX))
            r = Q_MAX;
        else if (v < 49'(Q_MIN))
            r = Q_MIN;
        else
            r = v[W-1:0];
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else
            v8_reg <= v7_reg;
    end

    always_ff @(posedge clk)
    begin
        p8_reg   <= p7_reg;
        t8_reg   <= t7_reg;
        in8_reg  <= in7_reg;
        // a component beyond the radius misses, which keeps each squared operand in 32 bits
        far8_reg <= (mx8 > 50'(rmag)) || (my8 > 50'(rmag)) || (mz8 > 50'(rmag));
        mx8_reg  <= mx8[W-1:0];
        my8_reg  <= my8[W-1:0];
        mz8_reg  <= mz8[W-1:0];
        px8_reg  <= sat49(ptx7_reg);
        py8_reg  <= sat49(pty7_reg);
        pz8_reg  <= sat49(ptz7_reg);
    end

    // ---------------- stage 41: squares ----------------
    logic                      v9_reg;
    pay_t                      p9_reg;
    logic signed [W-1:0]       t9_reg;
    logic                      ok9_reg;
    logic [2*W-1:0]            sx9_reg, sy9_reg, sz9_reg;
    logic signed [W-1:0]       px9_reg, py9_reg, pz9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9_reg <= 1'b0;
        else
            v9_reg <= v8_reg;
    end

    always_ff @(posedge clk)
    begin
        p9_reg  <= p8_reg;
        t9_reg  <= t8_reg;
        ok9_reg <= in8_reg && !far8_reg && !p8_reg.den_zero;
        sx9_reg <= mx8_reg * mx8_reg;
        sy9_reg <= my8_reg * my8_reg;
        sz9_reg <= mz8_reg * mz8_reg;
        px9_reg <= px8_reg;
        py9_reg <= py8_reg;
        pz9_reg <= pz8_reg;
    end

    // ---------------- stage 42: distance test, normal, output register ----------------
    logic [2*W+1:0]            dist2;
    logic                      hit_c;
    logic                      front_c;
    logic signed [W-1:0]       onx, ony, onz;

    assign dist2   = (2*W+2)'(sx9_reg) + (2*W+2)'(sy9_reg) + (2*W+2)'(sz9_reg);
    assign hit_c   = ok9_reg && (dist2 <= (2*W+2)'(r2_reg));
    // dot(dir, outward) is denom for the top cap, -denom for the bottom
    assign front_c = p9_reg.side ? p9_reg.den_neg : (!p9_reg.den_neg && !p9_reg.den_zero);
    assign onx     = p9_reg.side ? axis_x_reg : neg_sat(axis_x_reg);
    assign ony     = p9_reg.side ? axis_y_reg : neg_sat(axis_y_reg);
    assign onz     = p9_reg.side ? axis_z_reg : neg_sat(axis_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= v9_reg;
    end

    // a miss clears every result field
    always_ff @(posedge clk)
    begin
        hit        <= hit_c;
        t_hit      <= hit_c ? t9_reg  : '0;
        point_x    <= hit_c ? px9_reg : '0;
        point_y    <= hit_c ? py9_reg : '0;
        point_z    <= hit_c ? pz9_reg : '0;
        norm_x     <= !hit_c ? '0 : (front_c ? onx : neg_sat(onx));
        norm_y     <= !hit_c ? '0 : (front_c ? ony : neg_sat(ony));
        norm_z     <= !hit_c ? '0 : (front_c ? onz : neg_sat(onz));
        front_face <= hit_c && front_c;
    end

    // ---------------- assertions ----------------
    // every accepted transaction yields its result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after pipeline latency");

    // stage 1 is never valid without an accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> $past(accept))
        else $error("stage 1 valid without accepted transaction");

    // a miss reports zero t_hit, point_x, norm_z and front_face
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (t_hit == '0 && point_x == '0 && norm_z == '0 && !front_face))
        else $error("miss result carries nonzero fields");

endmodule
`default_nettype wire
